// ----- sv/mesm_pkg.sv -----
// ----------------------------------------------------------------------------
// mesm_pkg
// Shared types and constants of the multi-channel encoder speed meter.
// ----------------------------------------------------------------------------
package mesm_pkg;

    localparam int ELAPSED_W   = 24;
    localparam int CHAN_W      = 3;
    localparam int CFG_W       = 8;
    localparam int CFG_INDEX_W = 1;
    localparam int SPEED_W     = 48;
    localparam int SUM_OUT_W   = 19;
    localparam int FAULT_OUT_W = 3;
    localparam int US_W        = 20;
    localparam int FRAC_BITS   = 16;

    localparam logic [US_W-1:0]        US_PER_S      = 20'd1000000;
    localparam logic [SUM_OUT_W-1:0]   SUM_OUT_MAX   = '1;
    localparam logic [FAULT_OUT_W-1:0] FAULT_OUT_MAX = '1;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_THRESHOLD  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_PULSES = 1'd1;

    localparam logic [CFG_W-1:0] THRESHOLD_RESET  = 8'd3;
    localparam logic [CFG_W-1:0] MIN_PULSES_RESET = 8'd2;

    // item kinds
    localparam logic ACT_EDGE    = 1'b0;
    localparam logic ACT_MEASURE = 1'b1;

    typedef struct packed {
        logic [CFG_W-1:0] threshold;
        logic [CFG_W-1:0] min_pulses;
    } cfg_t;

endpackage

// ----- sv/mesm_front.sv -----
// ----------------------------------------------------------------------------
// mesm_front
// Edge counters. Takes one word per cycle while the snapshot queue is not
// full; an edge bumps its channel's saturating counter, a measure snapshots
// all counters into the queue and clears them.
// ----------------------------------------------------------------------------
module mesm_front #(
    parameter int CHANNELS    = 5,
    parameter int COUNT_WIDTH = 16,
    localparam int SNAP_W     = CHANNELS * COUNT_WIDTH + 1 + mesm_pkg::ELAPSED_W
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    output logic                             full,
    input  logic                             action,
    input  logic [mesm_pkg::CHAN_W-1:0]      channel,
    input  logic [mesm_pkg::ELAPSED_W-1:0]   elapsed_us,
    output logic                             snap_push,
    output logic [SNAP_W-1:0]                snap_data,
    input  logic                             snap_full
);
    import mesm_pkg::*;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    logic [COUNT_WIDTH-1:0] cnt_reg  [CHANNELS];
    logic [COUNT_WIDTH-1:0] cnt_next [CHANNELS];
    logic                   ovf_reg;
    logic                   ovf_next;
    logic                   accept;

    assign full      = snap_full;
    assign accept    = push && !snap_full;
    assign snap_push = accept && (action == ACT_MEASURE);

    always_comb
    begin
        ovf_next = ovf_reg;
        for (int c = 0; c < CHANNELS; c++)
        begin
            cnt_next[c] = cnt_reg[c];
            if (accept && action == ACT_MEASURE)
            begin
                cnt_next[c] = '0;
            end
            else if (accept && action == ACT_EDGE && 32'(channel) == c)
            begin
                if (cnt_reg[c] != COUNT_MAX)
                begin
                    cnt_next[c] = cnt_reg[c] + 1'b1;
                end
                // flag once the counter lands on its top value
                if (cnt_reg[c] >= COUNT_MAX - 1'b1)
                begin
                    ovf_next = 1'b1;
                end
            end
        end
        if (accept && action == ACT_MEASURE)
        begin
            ovf_next = 1'b0;
        end
    end

    always_comb
    begin
        snap_data = '0;
        for (int c = 0; c < CHANNELS; c++)
        begin
            snap_data[c*COUNT_WIDTH +: COUNT_WIDTH] = cnt_reg[c];
        end
        snap_data[CHANNELS*COUNT_WIDTH] = ovf_reg;
        snap_data[SNAP_W-1 -: ELAPSED_W] = elapsed_us;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                cnt_reg[c] <= '0;
            end
            ovf_reg <= 1'b0;
        end
        else
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                cnt_reg[c] <= cnt_next[c];
            end
            ovf_reg <= ovf_next;
        end
    end

    a_snap_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        snap_push |-> !snap_full)
        else $error("snapshot pushed into a full queue");

endmodule

// ----- sv/mesm_queue.sv -----
// ----------------------------------------------------------------------------
// mesm_queue
// Short register queue of measure snapshots between the counters and the
// speed calculation.
// ----------------------------------------------------------------------------
module mesm_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             valid
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_wr, do_rd;

    assign full    = (cnt_reg == CNT_W'(DEPTH));
    assign valid   = (cnt_reg != '0);
    assign rd_data = mem_reg[rd_ptr_reg];
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(cnt_reg) <= DEPTH)
        else $error("queue fill count above depth");

endmodule

// ----- sv/mesm_back.sv -----
// ----------------------------------------------------------------------------
// mesm_back
// Speed calculation. Walks the snapshot one channel a cycle to drop faulty
// channels, scales the sum by one million in two partial products, then runs
// a bit-serial restoring divide and parks the word in the output register.
// ----------------------------------------------------------------------------
module mesm_back #(
    parameter int CHANNELS    = 5,
    parameter int COUNT_WIDTH = 16,
    localparam int SNAP_W     = CHANNELS * COUNT_WIDTH + 1 + mesm_pkg::ELAPSED_W
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  mesm_pkg::cfg_t                      cfg,
    input  logic                                q_valid,
    input  logic [SNAP_W-1:0]                   q_data,
    output logic                                q_pop,
    output logic                                empty,
    input  logic                                pop,
    output logic [mesm_pkg::SPEED_W-1:0]        speed_q16,
    output logic [mesm_pkg::SUM_OUT_W-1:0]      pulse_sum,
    output logic [mesm_pkg::FAULT_OUT_W-1:0]    fault_count,
    output logic                                saturated
);
    import mesm_pkg::*;

    localparam int IDX_W    = $clog2(CHANNELS);
    localparam int CH_W     = $clog2(CHANNELS + 1);
    localparam int CW1      = COUNT_WIDTH + 1;
    localparam int SUM_W    = COUNT_WIDTH + $clog2(CHANNELS);
    localparam int DEN_W    = CH_W + ELAPSED_W;
    localparam int LO_W     = (SUM_W + 1) / 2;
    localparam int HI_W     = SUM_W - LO_W;
    localparam int NUM_W    = SUM_W + US_W;
    localparam int DIV_BITS = NUM_W + FRAC_BITS;
    localparam int DCNT_W   = $clog2(DIV_BITS + 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_WALK = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_ADD  = 3'd3;
    localparam logic [2:0] ST_DIV  = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    logic [2:0]             state_reg, state_next;
    logic [COUNT_WIDTH-1:0] cnt_reg [CHANNELS];
    logic                   ovf_reg, ovf_next;
    logic [ELAPSED_W-1:0]   elapsed_reg, elapsed_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic [COUNT_WIDTH-1:0] prev_reg, prev_next;
    logic [SUM_W-1:0]       run_reg, run_next;
    logic [IDX_W-1:0]       faults_reg, faults_next;
    logic [DEN_W-1:0]       den_reg, den_next;
    logic [LO_W+US_W-1:0]   plo_reg, plo_next;
    logic [DIV_BITS-1:0]    dvd_reg, dvd_next;
    logic [DEN_W-1:0]       rem_reg, rem_next;
    logic [SPEED_W-1:0]     quo_reg, quo_next;
    logic                   qovf_reg, qovf_next;
    logic [DCNT_W-1:0]      bits_reg, bits_next;

    logic                   out_valid_reg, out_valid_next;
    logic [SPEED_W-1:0]     speed_reg, speed_next;
    logic [SUM_OUT_W-1:0]   sum_reg, sum_next;
    logic [FAULT_OUT_W-1:0] fault_reg, fault_next;
    logic                   sat_reg, sat_next;

    logic [COUNT_WIDTH-1:0] cur;
    logic [CW1-1:0]         cur_x, prev_x, thr_x, min_x;
    logic                   drop, swap;
    logic [CH_W-1:0]        ch_left;
    logic [HI_W+US_W-1:0]   phi;
    logic [NUM_W-1:0]       num;
    logic [DEN_W:0]         trial;
    logic                   ge;
    logic                   spd_max, sum_sat, load_snap;

    assign cur    = cnt_reg[idx_reg];
    assign cur_x  = CW1'(cur);
    assign prev_x = CW1'(prev_reg);
    assign thr_x  = CW1'(cfg.threshold);
    assign min_x  = CW1'(cfg.min_pulses);
    // signed neighbor differences, rearranged so both sides stay unsigned
    assign drop   = (cur_x + thr_x < prev_x) && (cur_x < min_x);
    assign swap   = (idx_reg == IDX_W'(1)) && (cur_x > prev_x + thr_x) && (prev_x < min_x);

    assign ch_left = CH_W'(CHANNELS) - CH_W'(faults_reg);
    assign phi     = run_reg[SUM_W-1:LO_W] * US_PER_S;
    assign num     = NUM_W'(plo_reg) + {phi, {LO_W{1'b0}}};

    assign trial = {rem_reg, dvd_reg[DIV_BITS-1]};
    assign ge    = (trial >= (DEN_W+1)'(den_reg));

    assign spd_max = (den_reg == '0) || qovf_reg || (&quo_reg);
    assign sum_sat = 64'(run_reg) > 64'(SUM_OUT_MAX);

    assign load_snap = (state_reg == ST_IDLE) && q_valid;
    assign q_pop     = load_snap;
    assign empty     = !out_valid_reg;
    assign speed_q16   = speed_reg;
    assign pulse_sum   = sum_reg;
    assign fault_count = fault_reg;
    assign saturated   = sat_reg;

    always_comb
    begin
        state_next     = state_reg;
        ovf_next       = ovf_reg;
        elapsed_next   = elapsed_reg;
        idx_next       = idx_reg;
        prev_next      = prev_reg;
        run_next       = run_reg;
        faults_next    = faults_reg;
        den_next       = den_reg;
        plo_next       = plo_reg;
        dvd_next       = dvd_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        qovf_next      = qovf_reg;
        bits_next      = bits_reg;
        out_valid_next = out_valid_reg;
        speed_next     = speed_reg;
        sum_next       = sum_reg;
        fault_next     = fault_reg;
        sat_next       = sat_reg;

        if (pop && out_valid_reg)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    ovf_next     = q_data[CHANNELS*COUNT_WIDTH];
                    elapsed_next = q_data[SNAP_W-1 -: ELAPSED_W];
                    prev_next    = q_data[COUNT_WIDTH-1:0];
                    run_next     = SUM_W'(q_data[COUNT_WIDTH-1:0]);
                    idx_next     = IDX_W'(1);
                    faults_next  = '0;
                    state_next   = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (drop)
                begin
                    faults_next = faults_reg + 1'b1;
                end
                else if (swap)
                begin
                    // running equals channel 0 here, so the swap leaves channel 1 alone
                    run_next    = SUM_W'(cur);
                    faults_next = faults_reg + 1'b1;
                end
                else
                begin
                    run_next = run_reg + SUM_W'(cur);
                end
                prev_next = cur;
                idx_next  = idx_reg + 1'b1;
                if (idx_reg == IDX_W'(CHANNELS - 1))
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                den_next   = DEN_W'(ch_left) * DEN_W'(elapsed_reg);
                plo_next   = run_reg[LO_W-1:0] * US_PER_S;
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                dvd_next  = {num, {FRAC_BITS{1'b0}}};
                rem_next  = '0;
                quo_next  = '0;
                qovf_next = 1'b0;
                bits_next = DCNT_W'(DIV_BITS);
                // skip the divide when the answer is already fixed
                if (run_reg == '0 || den_reg == '0)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                rem_next  = ge ? DEN_W'(trial - (DEN_W+1)'(den_reg)) : trial[DEN_W-1:0];
                quo_next  = {quo_reg[SPEED_W-2:0], ge};
                qovf_next = qovf_reg | quo_reg[SPEED_W-1];
                dvd_next  = {dvd_reg[DIV_BITS-2:0], 1'b0};
                bits_next = bits_reg - 1'b1;
                if (bits_reg == DCNT_W'(1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || pop)
                begin
                    if (run_reg == '0)
                    begin
                        speed_next = '0;
                    end
                    else if (spd_max)
                    begin
                        speed_next = '1;
                    end
                    else
                    begin
                        speed_next = quo_reg;
                    end
                    sum_next   = sum_sat ? SUM_OUT_MAX : SUM_OUT_W'(run_reg);
                    fault_next = (32'(faults_reg) > 32'(FAULT_OUT_MAX)) ?
                                 FAULT_OUT_MAX : FAULT_OUT_W'(faults_reg);
                    sat_next   = ovf_reg || sum_sat || ((run_reg != '0) && spd_max);
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (load_snap)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                cnt_reg[c] <= q_data[c*COUNT_WIDTH +: COUNT_WIDTH];
            end
        end
        ovf_reg     <= ovf_next;
        elapsed_reg <= elapsed_next;
        prev_reg    <= prev_next;
        run_reg     <= run_next;
        den_reg     <= den_next;
        plo_reg     <= plo_next;
        dvd_reg     <= dvd_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        qovf_reg    <= qovf_next;
        speed_reg   <= speed_next;
        sum_reg     <= sum_next;
        fault_reg   <= fault_next;
        sat_reg     <= sat_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            faults_reg    <= '0;
            bits_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            faults_reg    <= faults_next;
            bits_reg      <= bits_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> den_reg != '0)
        else $error("divide running with a zero divisor");

    a_pop_has_data: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("snapshot taken from an empty queue");

    a_fault_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_WALK |-> 32'(faults_reg) < 32'(idx_reg))
        else $error("more faults than channels walked");

endmodule

// ----- sv/multi_encoder_speed_meter.sv -----
// ----------------------------------------------------------------------------
// multi_encoder_speed_meter
// Counts encoder edges on several channels and, on a measure word, reports
// the pulse sum, wire faults and average pulse rate in Q16 hertz.
// ----------------------------------------------------------------------------
//  channel   handshake          payload
//  in        push / full        action, channel, elapsed_us
//  result    pop / empty        speed_q16, pulse_sum, fault_count, saturated
//  config    cfg_valid/ready    cfg_index, cfg_data
//
//  Edge words are taken one per cycle while full is low; full rises only
//  while the snapshot queue (two entries) is full.
//  A measure word is written into the snapshot queue as it is accepted; its
//  result then passes the channel walk, the two scaling steps and the
//  divider, which makes one quotient bit a cycle; a zero sum or zero time
//  skips the divide.
//  A waiting result stalls only the final write of the next one.
//  Reset clears counters, queue and result; config returns to 3 and 2.
// ----------------------------------------------------------------------------
module multi_encoder_speed_meter #(
    parameter int CHANNELS    = 5,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 push,
    output logic                                 full,
    input  logic                                 action,
    input  logic [mesm_pkg::CHAN_W-1:0]          channel,
    input  logic [mesm_pkg::ELAPSED_W-1:0]       elapsed_us,
    output logic                                 empty,
    input  logic                                 pop,
    output logic [mesm_pkg::SPEED_W-1:0]         speed_q16,
    output logic [mesm_pkg::SUM_OUT_W-1:0]       pulse_sum,
    output logic [mesm_pkg::FAULT_OUT_W-1:0]     fault_count,
    output logic                                 saturated,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [mesm_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [mesm_pkg::CFG_W-1:0]           cfg_data
);
    import mesm_pkg::*;

    localparam int SNAP_W = CHANNELS * COUNT_WIDTH + 1 + ELAPSED_W;

    cfg_t              cfg_reg, cfg_next;
    logic              snap_push, snap_full, snap_valid, snap_pop;
    logic [SNAP_W-1:0] snap_wdata, snap_rdata;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_THRESHOLD:  cfg_next.threshold  = cfg_data;
                CFG_MIN_PULSES: cfg_next.min_pulses = cfg_data;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.threshold  <= THRESHOLD_RESET;
            cfg_reg.min_pulses <= MIN_PULSES_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    mesm_front #(
        .CHANNELS    (CHANNELS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .action     (action),
        .channel    (channel),
        .elapsed_us (elapsed_us),
        .snap_push  (snap_push),
        .snap_data  (snap_wdata),
        .snap_full  (snap_full)
    );

    mesm_queue #(
        .WIDTH (SNAP_W),
        .DEPTH (2)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (snap_push),
        .wr_data (snap_wdata),
        .full    (snap_full),
        .rd_en   (snap_pop),
        .rd_data (snap_rdata),
        .valid   (snap_valid)
    );

    mesm_back #(
        .CHANNELS    (CHANNELS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .q_valid     (snap_valid),
        .q_data      (snap_rdata),
        .q_pop       (snap_pop),
        .empty       (empty),
        .pop         (pop),
        .speed_q16   (speed_q16),
        .pulse_sum   (pulse_sum),
        .fault_count (fault_count),
        .saturated   (saturated)
    );

endmodule
